// ===== src/prsf_pkg.sv =====
`timescale 1ns / 1ps
package prsf_pkg;

  // Field widths of the scan and report items
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 32;
  localparam int LENGTH_W = 32;
  localparam int COUNT_W  = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int NEEDLE_LEN_W = 5;
  localparam int NEEDLE_BYTES = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEEDLE_LOW  = 3'd0,
    REG_NEEDLE_HIGH = 3'd1,
    REG_NEEDLE_LEN  = 3'd2,
    REG_MIN_LENGTH  = 3'd3,
    REG_MAX_MATCHES = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic [COUNT_W-1:0] MIN_LENGTH_RESET  = 16'd6;
  localparam logic [COUNT_W-1:0] MAX_MATCHES_RESET = 16'd20000;

  // Printable ASCII range and uppercase range
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7e;
  localparam logic [BYTE_W-1:0] UPPER_LO = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_HI = 8'h5a;
  localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

  localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]   needle_low;
    logic [CFG_DATA_W-1:0]   needle_high;
    logic [NEEDLE_LEN_W-1:0] needle_length;
    logic [COUNT_W-1:0]      min_length;
    logic [COUNT_W-1:0]      max_matches;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

  function automatic logic in_print_range(input logic [BYTE_W-1:0] c);
    return (c >= PRINT_LO) && (c <= PRINT_HI);
  endfunction

endpackage

// ===== src/prsf_if.sv =====
`timescale 1ns / 1ps
// Scan channel: one memory byte per item
interface prsf_scan_if import prsf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   data_byte;
  logic [OFFSET_W-1:0] byte_offset;
  logic                region_last;
  logic                new_scan;

  modport source(output valid, data_byte, byte_offset, region_last, new_scan, input ready);
  modport sink(input valid, data_byte, byte_offset, region_last, new_scan, output ready);
endinterface

// Report channel: one matching run per item
interface prsf_report_if import prsf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] string_offset;
  logic [LENGTH_W-1:0] string_length;
  logic [COUNT_W-1:0]  match_number;

  modport source(output valid, string_offset, string_length, match_number, input ready);
  modport sink(input valid, string_offset, string_length, match_number, output ready);
endinterface

// ===== src/prsf_cfg_regs.sv =====
`timescale 1ns / 1ps
module prsf_cfg_regs import prsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.needle_low    <= '0;
      cfg.needle_high   <= '0;
      cfg.needle_length <= '0;
      cfg.min_length    <= MIN_LENGTH_RESET;
      cfg.max_matches   <= MAX_MATCHES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NEEDLE_LOW:  cfg.needle_low    <= cfg_data;
        REG_NEEDLE_HIGH: cfg.needle_high   <= cfg_data;
        REG_NEEDLE_LEN:  cfg.needle_length <= cfg_data[NEEDLE_LEN_W-1:0];
        REG_MIN_LENGTH:  cfg.min_length    <= cfg_data[COUNT_W-1:0];
        REG_MAX_MATCHES: cfg.max_matches   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/prsf_window_match.sv =====
`timescale 1ns / 1ps
module prsf_window_match import prsf_pkg::*; #(
  parameter int NEEDLE_MAX = 16
) (
  input  logic [NEEDLE_MAX-1:0][BYTE_W-1:0] window,
  input  logic [LENGTH_W-1:0]               run_count,
  input  cfg_t                              cfg,
  output logic                              hit
);

  localparam int LW = $clog2(NEEDLE_MAX + 1);
  localparam logic [NEEDLE_LEN_W-1:0] NMAX = NEEDLE_LEN_W'(NEEDLE_MAX);

  logic [NEEDLE_MAX-1:0][BYTE_W-1:0] needle;
  logic [LW-1:0]                     n_used;
  logic [NEEDLE_MAX:1]               len_match;
  logic                              sel_match;

  // Unpack needle bytes, byte zero lowest
  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      if (k < 8) begin
        needle[k] = cfg.needle_low[8*k +: 8];
      end else begin
        needle[k] = cfg.needle_high[8*(k-8) +: 8];
      end
    end
  end

  // Clamp the needle length to the window depth
  assign n_used = (cfg.needle_length > NMAX) ? LW'(NEEDLE_MAX) : LW'(cfg.needle_length);

  // Compare every candidate length in parallel: needle byte i sits at entry n-1-i
  always_comb begin
    for (int n = 1; n <= NEEDLE_MAX; n++) begin
      len_match[n] = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (window[n-1-i] != needle[i]) begin
          len_match[n] = 1'b0;
        end
      end
    end
  end

  // Pick the result for the length in use
  always_comb begin
    sel_match = 1'b0;
    for (int n = 1; n <= NEEDLE_MAX; n++) begin
      if (n_used == LW'(n)) begin
        sel_match = len_match[n];
      end
    end
  end

  assign hit = (n_used == '0) ||
               (sel_match && (run_count >= LENGTH_W'(n_used)));

endmodule

// ===== src/printable_run_substring_finder.sv =====
`timescale 1ns / 1ps
// Printable run substring finder. Takes one memory byte per scan item and
// tracks runs of printable ASCII (0x20..0x7e). A run closes at a non-printable
// byte or after a byte marked region_last; a closed run at least min_length
// long whose lowercased text contains the needle (needle_length bytes, empty
// matches all) is sent as one report item with its start offset, saturating
// length and match number. After max_matches reports, bytes are ignored until
// an item with new_scan set. One scan item is taken every cycle unless stalled;
// a byte is captured in the input register, processed against the run state and
// the parallel needle window compare, and its report is registered in the output
// register. The scan side stalls only while the output register holds an untaken
// report. Configuration must be written while idle; the block does not enforce it.
module printable_run_substring_finder import prsf_pkg::*; #(
  parameter int NEEDLE_MAX = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  prsf_scan_if.sink              scan,
  prsf_report_if.source          report
);

  cfg_t cfg;

  // Input register
  logic                s1_valid;
  logic [BYTE_W-1:0]   s1_byte;
  logic [OFFSET_W-1:0] s1_offset;
  logic                s1_last;
  logic                s1_fresh;
  logic                s1_adv;

  // Run state
  logic [NEEDLE_MAX-1:0][BYTE_W-1:0] window;
  logic [NEEDLE_MAX-1:0][BYTE_W-1:0] window_next;
  logic                run_open;
  logic [OFFSET_W-1:0] run_origin;
  logic [LENGTH_W-1:0] run_count;
  logic                needle_seen;
  logic [COUNT_W-1:0]  report_count;

  // Per item work
  logic                open_eff;
  logic [LENGTH_W-1:0] count_eff;
  logic                seen_eff;
  logic [COUNT_W-1:0]  rc_eff;
  logic                limit;
  logic                printable;
  logic [LENGTH_W-1:0] count_base;
  logic [LENGTH_W-1:0] count_next;
  logic                seen_next;
  logic [OFFSET_W-1:0] start_next;
  logic                closing;
  logic                win_hit;
  logic                hit;

  prsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  prsf_window_match #(.NEEDLE_MAX(NEEDLE_MAX)) u_match (
    .window    (window_next),
    .run_count (count_next),
    .cfg       (cfg),
    .hit       (win_hit)
  );

  assign s1_adv     = !report.valid || report.ready;
  assign scan.ready = !s1_valid || s1_adv;

  // Capture the next scan item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
    if (scan.ready && scan.valid) begin
      s1_byte   <= scan.data_byte;
      s1_offset <= scan.byte_offset;
      s1_last   <= scan.region_last;
      s1_fresh  <= scan.new_scan;
    end
  end

  // Apply new_scan, then extend or close the run
  always_comb begin
    open_eff  = s1_fresh ? 1'b0 : run_open;
    count_eff = s1_fresh ? '0 : run_count;
    seen_eff  = s1_fresh ? 1'b0 : needle_seen;
    rc_eff    = s1_fresh ? '0 : report_count;
    limit     = rc_eff >= cfg.max_matches;
    printable = in_print_range(s1_byte);

    window_next[0] = fold_lower(s1_byte);
    for (int k = 1; k < NEEDLE_MAX; k++) begin
      window_next[k] = window[k-1];
    end

    if (printable) begin
      count_base = open_eff ? count_eff : '0;
      count_next = (count_base == LENGTH_MAX) ? count_base : count_base + 1'b1;
      seen_next  = (open_eff && seen_eff) || win_hit;
      start_next = open_eff ? run_origin : s1_offset;
      closing    = s1_last;
    end else begin
      count_base = count_eff;
      count_next = count_eff;
      seen_next  = seen_eff;
      start_next = run_origin;
      closing    = open_eff;
    end

    hit = closing && (count_next >= LENGTH_W'(cfg.min_length)) &&
          ((cfg.needle_length == '0) || seen_next);
  end

  // Update run state once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open     <= 1'b0;
      run_origin   <= '0;
      run_count    <= '0;
      needle_seen  <= 1'b0;
      report_count <= '0;
    end else if (s1_valid && s1_adv) begin
      if (limit || closing) begin
        run_open    <= 1'b0;
        run_count   <= '0;
        needle_seen <= 1'b0;
      end else begin
        run_open    <= open_eff || printable;
        run_count   <= count_next;
        needle_seen <= seen_next;
        run_origin  <= start_next;
      end
      report_count <= (!limit && hit) ? rc_eff + 1'b1 : rc_eff;
    end
  end

  // Shift the lowercased byte into the window
  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv && printable && !limit) begin
      window <= window_next;
    end
  end

  // Hold the report until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (s1_valid && s1_adv && !limit && hit) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
    if (s1_valid && s1_adv && !limit && hit) begin
      report.string_offset <= start_next;
      report.string_length <= count_next;
      report.match_number  <= rc_eff + 1'b1;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import prsf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
    logic                region_last;
    logic                new_scan;
  } scan_byte_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [COUNT_W-1:0]  number;
  } run_report_t;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_SHOWN     = 10;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  prsf_scan_if   scan_ch();
  prsf_report_if report_ch();

  printable_run_substring_finder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan_ch),
    .report    (report_ch)
  );

  // Bytes waiting to be sent and the reports they should produce
  scan_byte_t  byte_queue[$];
  run_report_t predicted_reports[$];
  scan_byte_t  shown_byte;
  run_report_t oldest;

  int scan_gap_pct     = 36;
  int report_stall_pct = 48;
  int bytes_taken      = 0;
  int reports_checked  = 0;
  int reg_writes       = 0;
  int failures         = 0;
  int cycles           = 0;
  logic [OFFSET_W-1:0] next_offset;

  // Register copy
  logic [CFG_DATA_W-1:0]   needle_lo;
  logic [CFG_DATA_W-1:0]   needle_hi;
  logic [NEEDLE_LEN_W-1:0] needle_len;
  logic [COUNT_W-1:0]      min_len;
  logic [COUNT_W-1:0]      max_reports;

  // Run tracking state
  logic [BYTE_W-1:0]   run_tail [NEEDLE_BYTES];
  logic                run_active;
  logic [OFFSET_W-1:0] run_origin;
  logic [LENGTH_W-1:0] run_len;
  logic                needle_found;
  logic [COUNT_W-1:0]  reports_made;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cap the run length
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports still due", cycles,
               predicted_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int needle_used();
    return (needle_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len);
  endfunction

  function automatic logic [BYTE_W-1:0] needle_char(int k);
    return (k < 8) ? needle_lo[8*k +: 8] : needle_hi[8*(k-8) +: 8];
  endfunction

  function automatic logic [BYTE_W-1:0] lower_case(logic [BYTE_W-1:0] c);
    return (c >= UPPER_LO && c <= UPPER_HI) ? c + CASE_GAP : c;
  endfunction

  // Compare the newest run bytes against the needle, oldest byte first
  function automatic bit window_hit();
    int n;
    n = needle_used();
    if (n == 0) return 1'b1;
    if (run_len < n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (run_tail[n-1-i] != needle_char(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_run();
    run_active   = 1'b0;
    run_len      = '0;
    needle_found = 1'b0;
    foreach (run_tail[i]) run_tail[i] = '0;
  endfunction

  // Advance the run state by one accepted byte and queue any report
  task automatic track_byte(scan_byte_t b);
    logic        closing;
    logic        hit;
    run_report_t r;
    if (b.new_scan) begin
      reports_made = '0;
      clear_run();
    end
    // Drop everything once the report limit is reached
    if (reports_made >= max_reports) begin
      clear_run();
      return;
    end
    if (b.data >= PRINT_LO && b.data <= PRINT_HI) begin
      if (!run_active) begin
        clear_run();
        run_active = 1'b1;
        run_origin = b.offset;
      end
      for (int i = NEEDLE_BYTES - 1; i > 0; i--) run_tail[i] = run_tail[i-1];
      run_tail[0] = lower_case(b.data);
      if (run_len != LENGTH_MAX) run_len++;
      if (window_hit()) needle_found = 1'b1;
      closing = b.region_last;
    end else begin
      closing = run_active;
    end
    if (closing && run_active) begin
      hit      = (run_len >= min_len) && (needle_used() == 0 || needle_found);
      r.offset = run_origin;
      r.length = run_len;
      clear_run();
      if (hit) begin
        reports_made++;
        r.number = reports_made;
        predicted_reports.push_back(r);
      end
    end
  endtask

  // Scan driver: present the next byte once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      scan_ch.valid       <= 1'b0;
      scan_ch.data_byte   <= '0;
      scan_ch.byte_offset <= '0;
      scan_ch.region_last <= 1'b0;
      scan_ch.new_scan    <= 1'b0;
    end else begin
      if (scan_ch.valid && scan_ch.ready) begin
        track_byte(shown_byte);
        bytes_taken++;
      end
      if (!scan_ch.valid || scan_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= scan_gap_pct) begin
          shown_byte = byte_queue.pop_front();
          scan_ch.valid       <= 1'b1;
          scan_ch.data_byte   <= shown_byte.data;
          scan_ch.byte_offset <= shown_byte.offset;
          scan_ch.region_last <= shown_byte.region_last;
          scan_ch.new_scan    <= shown_byte.new_scan;
        end else begin
          scan_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: check each taken item against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (predicted_reports.size() == 0) begin
          failures++;
          if (failures <= MAX_SHOWN)
            $display("Unexpected report: offset %h length %0d number %0d",
                     report_ch.string_offset, report_ch.string_length,
                     report_ch.match_number);
        end else begin
          oldest = predicted_reports.pop_front();
          reports_checked++;
          if (report_ch.string_offset !== oldest.offset ||
              report_ch.string_length !== oldest.length ||
              report_ch.match_number !== oldest.number) begin
            failures++;
            if (failures <= MAX_SHOWN)
              $display({"Report mismatch: expected offset %h length %0d number %0d, ",
                        "got offset %h length %0d number %0d"},
                       oldest.offset, oldest.length, oldest.number,
                       report_ch.string_offset, report_ch.string_length,
                       report_ch.match_number);
          end
        end
      end
      report_ch.ready <= ($urandom_range(99) >= report_stall_pct);
    end
  end

  function automatic logic [OFFSET_W-1:0] advance_offset();
    if ($urandom_range(19) == 0) next_offset = $urandom;
    else next_offset++;
    return next_offset;
  endfunction

  function automatic logic [8*NEEDLE_BYTES-1:0] text_bits(string s);
    logic [8*NEEDLE_BYTES-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < NEEDLE_BYTES; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // Build a needle of printable bytes that are never uppercase
  function automatic logic [8*NEEDLE_BYTES-1:0] random_needle(int n, bit letters_only);
    logic [8*NEEDLE_BYTES-1:0] v;
    logic [BYTE_W-1:0]         c;
    v = '0;
    for (int k = 0; k < n; k++) begin
      if (letters_only) c = BYTE_W'($urandom_range(UPPER_HI, UPPER_LO)) + CASE_GAP;
      else c = lower_case(BYTE_W'($urandom_range(PRINT_HI, PRINT_LO)));
      v[8*k +: 8] = c;
    end
    return v;
  endfunction

  task automatic queue_byte(logic [BYTE_W-1:0] d, logic [OFFSET_W-1:0] off,
                            logic last, logic fresh);
    scan_byte_t b;
    b.data        = d;
    b.offset      = off;
    b.region_last = last;
    b.new_scan    = fresh;
    byte_queue.push_back(b);
  endtask

  task automatic queue_text(string s, logic [OFFSET_W-1:0] base, logic last);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], base + i, last && (i == s.len() - 1), 1'b0);
  endtask

  // Write one register and mirror it in the register copy
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_NEEDLE_LOW:  needle_lo   = value;
      REG_NEEDLE_HIGH: needle_hi   = value;
      REG_NEEDLE_LEN:  needle_len  = value[NEEDLE_LEN_W-1:0];
      REG_MIN_LENGTH:  min_len     = value[COUNT_W-1:0];
      REG_MAX_MATCHES: max_reports = value[COUNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_needle(logic [8*NEEDLE_BYTES-1:0] bytes,
                            logic [NEEDLE_LEN_W-1:0] len_field);
    write_reg(REG_NEEDLE_LOW, bytes[63:0]);
    write_reg(REG_NEEDLE_HIGH, bytes[127:64]);
    write_reg(REG_NEEDLE_LEN, CFG_DATA_W'(len_field));
  endtask

  // Hold off until every byte is taken and every report has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || scan_ch.valid || predicted_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly printable words built around the needle, some cut short, some noise
  task automatic random_phase(int target);
    int                made;
    int                n;
    int                pick;
    int                keep;
    logic [BYTE_W-1:0] word[$];
    logic [BYTE_W-1:0] c;
    logic              start_fresh;
    logic              end_region;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 12) begin
        queue_byte(BYTE_W'($urandom_range(255)), advance_offset(),
                   $urandom_range(3) == 0, $urandom_range(15) == 0);
        made++;
      end else begin
        word.delete();
        n    = needle_used();
        pick = $urandom_range(9);
        if (pick < 7) keep = n;
        else if (pick == 7 && n > 1) keep = $urandom_range(n - 1, 1);
        else keep = 0;
        repeat ($urandom_range(4))
          word.push_back(BYTE_W'($urandom_range(PRINT_HI, PRINT_LO)));
        for (int k = 0; k < keep; k++) begin
          c = needle_char(k);
          if (c >= UPPER_LO + CASE_GAP && c <= UPPER_HI + CASE_GAP && $urandom_range(1))
            c = c - CASE_GAP;
          word.push_back(c);
        end
        repeat ($urandom_range(4))
          word.push_back(BYTE_W'($urandom_range(PRINT_HI, PRINT_LO)));
        if (word.size() == 0) word.push_back(BYTE_W'($urandom_range(PRINT_HI, PRINT_LO)));
        start_fresh = ($urandom_range(11) == 0);
        end_region  = ($urandom_range(1) == 1);
        foreach (word[k])
          queue_byte(word[k], advance_offset(), end_region && (k == word.size() - 1),
                     start_fresh && (k == 0));
        made += word.size();
        // Close the run with a control or high byte
        if (!end_region) begin
          if ($urandom_range(1)) c = BYTE_W'($urandom_range(PRINT_LO - 1, 0));
          else c = BYTE_W'($urandom_range(8'hff, PRINT_HI + 1));
          queue_byte(c, advance_offset(), $urandom_range(3) == 0, 1'b0);
          made++;
        end
      end
    end
  endtask

  // Stimulus
  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_NEEDLE_LOW;
    cfg_data     = '0;
    needle_lo    = '0;
    needle_hi    = '0;
    needle_len   = '0;
    min_len      = MIN_LENGTH_RESET;
    max_reports  = MAX_MATCHES_RESET;
    run_origin   = '0;
    reports_made = '0;
    clear_run();
    next_offset  = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Mixed case run at the top of the offset range, then printable extremes
    set_needle(text_bits("lo"), 5'd2);
    write_reg(REG_MIN_LENGTH, 64'd3);
    queue_text("HeLLo", 32'hffff_fffb, 1'b1);
    queue_byte(PRINT_LO, 32'h0000_0000, 1'b0, 1'b0);
    queue_byte("l", 32'h0000_0007, 1'b0, 1'b0);
    queue_byte("o", 32'h0000_0003, 1'b0, 1'b0);
    queue_byte(PRINT_HI, 32'h0000_0001, 1'b0, 1'b0);
    queue_byte(8'hff, 32'h0000_0002, 1'b0, 1'b0);
    wait_idle();

    // Oversized needle length with zero minimum, then swap needle mid-run
    set_needle(text_bits("abcdefghijklmnop"), 5'd31);
    write_reg(REG_MIN_LENGTH, 64'd0);
    queue_text("abcdefghijklmnop", 32'h0000_1000, 1'b0);
    wait_idle();
    set_needle(text_bits("q"), 5'd1);
    queue_byte("Z", 32'h0000_1010, 1'b1, 1'b0);
    wait_idle();

    // Uppercase needle never matches
    set_needle(text_bits("A"), 5'd1);
    write_reg(REG_MIN_LENGTH, 64'd1);
    queue_text("aA", 32'h0000_2000, 1'b0);
    queue_byte(PRINT_LO - 1, 32'h0000_2002, 1'b0, 1'b0);
    queue_byte(PRINT_HI + 1, 32'h0000_2003, 1'b0, 1'b0);
    wait_idle();

    // Report limit, restart by new scan, zero limit
    set_needle('0, 5'd0);
    write_reg(REG_MAX_MATCHES, 64'd1);
    queue_byte("x", 32'h0000_3000, 1'b1, 1'b1);
    queue_byte("y", 32'h0000_3001, 1'b1, 1'b0);
    queue_byte("z", 32'h0000_3002, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_MAX_MATCHES, 64'd0);
    queue_byte("q", 32'h0000_3003, 1'b1, 1'b1);
    wait_idle();

    // Random words, sender gaps lighter than receiver stalls
    write_reg(REG_MAX_MATCHES, CFG_DATA_W'(MAX_MATCHES_RESET));
    set_needle(random_needle(3, 1'b1), 5'd3);
    write_reg(REG_MIN_LENGTH, 64'd4);
    random_phase(100);
    wait_idle();

    set_needle('0, 5'd0);
    write_reg(REG_MIN_LENGTH, 64'd1);
    write_reg(REG_MAX_MATCHES, 64'd7);
    random_phase(100);
    wait_idle();

    // Swap the idling of the two sides
    scan_gap_pct     = 48;
    report_stall_pct = 36;
    set_needle(random_needle(16, 1'b0), 5'd16);
    write_reg(REG_MIN_LENGTH, 64'd16);
    write_reg(REG_MAX_MATCHES, 64'hffff);
    random_phase(100);
    wait_idle();

    begin
      logic [8*NEEDLE_BYTES-1:0] mixed;
      mixed = random_needle(5, 1'b1);
      mixed[127:64] = {$urandom, $urandom};
      set_needle(mixed, 5'd5);
    end
    write_reg(REG_MIN_LENGTH, 64'd0);
    write_reg(REG_MAX_MATCHES, 64'd30);
    random_phase(100);
    wait_idle();

    // Full rate on both sides
    scan_gap_pct     = 0;
    report_stall_pct = 0;
    write_reg(REG_MIN_LENGTH, 64'hffff);
    random_phase(40);
    wait_idle();

    set_needle(random_needle(1, 1'b1), 5'd1);
    write_reg(REG_MIN_LENGTH, 64'd2);
    write_reg(REG_MAX_MATCHES, 64'hffff);
    random_phase(110);
    wait_idle();

    $display("Scanned %0d bytes over %0d register writes; %0d reports checked, %0d failures",
             bytes_taken, reg_writes, reports_checked, failures);
    $display("Needles of 0 to 16 bytes, minimum lengths 0 to 65535, report limits 0 to 65535");
    if (failures == 0 && predicted_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/prsf_pkg.sv
src/prsf_if.sv
src/prsf_cfg_regs.sv
src/prsf_window_match.sv
src/printable_run_substring_finder.sv
tb/sv/testbench.sv
